### rtl/quadratic_bezier_point_generator_core_assert.svh
// Assertion macros for the quadratic Bezier point generator checker.
// No dependencies; included by the checker file.
`ifndef QUADRATIC_BEZIER_POINT_GENERATOR_CORE_ASSERT_SVH
`define QUADRATIC_BEZIER_POINT_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define QBPG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QBPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/qbpg_pkg.sv
// Shared constants and types for the quadratic Bezier point generator.
// No dependencies.
package qbpg_pkg;

	localparam int CFG_IDX_W    = 3;
	localparam int STEP_SHIFT_W = 4;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_START_POINT   = 3'd0;
	localparam cfg_idx_t REG_CONTROL_POINT = 3'd1;
	localparam cfg_idx_t REG_END_POINT     = 3'd2;
	localparam cfg_idx_t REG_STEP_SHIFT    = 3'd3;
	localparam cfg_idx_t REG_MARGIN_POINTS = 3'd4;
	localparam cfg_idx_t REG_DEDUPE_ENABLE = 3'd5;

	localparam logic [STEP_SHIFT_W-1:0] STEP_SHIFT_RST = 4'd13;
	localparam int                      MARGIN_RST     = 81;

endpackage

### rtl/quadratic_bezier_point_generator_core.sv
// Quadratic Bezier point generator: top level, config registers and sequencer.
// Depends on qbpg_pkg and qbpg_mul_unit.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  cfg      | cfg_wr_en            | cfg_index, cfg_data
//  in       | in_valid / in_ready  | step_index
//  out      | out_valid / out_ready| point_x, point_y, point_step
//
// An in-range item holds in_ready low until it is done, so no new item is taken
// while one is in progress: the multiplier works through nine products (coefficients,
// then x and y terms), then come a rounding shift and the dedupe decision. A step beyond the
// curve leaves in_ready high, so the next item can follow on the next cycle.
// The result sits in an output register; a new item is taken while it waits.
// A full output register holds the sequencer in its last state.
// Reset is asynchronous and clears all control state; no clearing pass.
module quadratic_bezier_point_generator_core #(
	parameter int COORD_BITS     = 24,
	parameter int MAX_STEP_SHIFT = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  qbpg_pkg::cfg_idx_t            cfg_index,
	input  logic [2*COORD_BITS-1:0]       cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [MAX_STEP_SHIFT:0]       step_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS-1:0]  point_x,
	output logic signed [COORD_BITS-1:0]  point_y,
	output logic [MAX_STEP_SHIFT:0]       point_step
);

	localparam int CB       = COORD_BITS;
	localparam int STEP_W   = MAX_STEP_SHIFT + 1;
	localparam int SHW      = $clog2(MAX_STEP_SHIFT + 1);
	localparam int PIX_W    = CB - 7;
	localparam int MA_W     = 2 * MAX_STEP_SHIFT + 1;
	localparam int MB_W     = (CB > STEP_W) ? CB : STEP_W;
	localparam int ACC_W    = 2 * MAX_STEP_SHIFT + CB;
	localparam int MARGIN_W = MAX_STEP_SHIFT;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MUL    = 2'd1;
	localparam logic [1:0] ST_SHIFT  = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	localparam logic [3:0] OP_AA   = 4'd0;
	localparam logic [3:0] OP_AB   = 4'd1;
	localparam logic [3:0] OP_BB   = 4'd2;
	localparam logic [3:0] OP_X0   = 4'd3;
	localparam logic [3:0] OP_X1   = 4'd4;
	localparam logic [3:0] OP_X2   = 4'd5;
	localparam logic [3:0] OP_Y0   = 4'd6;
	localparam logic [3:0] OP_Y1   = 4'd7;
	localparam logic [3:0] OP_Y2   = 4'd8;
	localparam logic [3:0] OP_DONE = 4'd9;

	localparam logic [CB-1:0] SIGN_BIT = {1'b1, {(CB-1){1'b0}}};

	logic [2*CB-1:0]                       p0_q, p1_q, p2_q;
	logic [qbpg_pkg::STEP_SHIFT_W-1:0]     shift_cfg_q;
	logic [MARGIN_W-1:0]                   margin_q;
	logic                                  dedupe_q;

	logic [1:0]          state_q;
	logic [3:0]          op_q;
	logic [STEP_W-1:0]   i_q, a_q;
	logic [SHW-1:0]      s_q;
	logic                middle_q;
	logic [MA_W-1:0]     c0_q, c1_q, c2_q;
	logic [ACC_W-1:0]    acc_x_q, acc_y_q;
	logic [CB-1:0]       px_q, py_q;
	logic                kept_valid_q;
	logic [PIX_W-1:0]    kept_x_q, kept_y_q;
	logic                out_valid_q;
	logic [CB-1:0]       out_x_q, out_y_q;
	logic [STEP_W-1:0]   out_step_q;

	logic [SHW-1:0]      s_eff;
	logic [STEP_W-1:0]   full;
	logic                in_range, middle, accept;
	logic [CB-1:0]       u0x, u1x, u2x, u0y, u1y, u2y;
	logic [MA_W-1:0]     mul_a;
	logic [MB_W-1:0]     mul_b;
	logic                mul_en;
	logic [MA_W+MB_W-1:0] prod;
	logic [ACC_W-1:0]    prod_n, prod_2;
	logic [ACC_W-1:0]    rx, ry;
	logic [PIX_W-1:0]    pix_x, pix_y;
	logic                drop, load_out;

	function automatic logic [PIX_W-1:0] pixel_of(input logic [CB-1:0] c);
		logic [CB-1:0]   mag;
		logic [CB-1:0]   rnd;
		logic [PIX_W-1:0] q;
		mag = c[CB-1] ? (~c + CB'(1)) : c;
		rnd = mag + CB'(128);
		q   = {1'b0, rnd[CB-1:8]};
		return c[CB-1] ? (~q + PIX_W'(1)) : q;
	endfunction

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_q        <= '0;
			p1_q        <= '0;
			p2_q        <= '0;
			shift_cfg_q <= qbpg_pkg::STEP_SHIFT_RST;
			margin_q    <= MARGIN_W'(qbpg_pkg::MARGIN_RST);
			dedupe_q    <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				qbpg_pkg::REG_START_POINT:   p0_q <= cfg_data;
				qbpg_pkg::REG_CONTROL_POINT: p1_q <= cfg_data;
				qbpg_pkg::REG_END_POINT:     p2_q <= cfg_data;
				qbpg_pkg::REG_STEP_SHIFT:
					shift_cfg_q <= cfg_data[qbpg_pkg::STEP_SHIFT_W-1:0];
				qbpg_pkg::REG_MARGIN_POINTS: margin_q <= cfg_data[MARGIN_W-1:0];
				qbpg_pkg::REG_DEDUPE_ENABLE: dedupe_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (shift_cfg_q == '0) begin
			s_eff = SHW'(1);
		end else if (int'(shift_cfg_q) > MAX_STEP_SHIFT) begin
			s_eff = SHW'(MAX_STEP_SHIFT);
		end else begin
			s_eff = SHW'(shift_cfg_q);
		end
	end

	assign full     = STEP_W'(1) << s_eff;
	assign in_range = (step_index <= full);
	assign middle   = (step_index >= STEP_W'(margin_q)) &&
		(({1'b0, step_index} + (STEP_W+1)'(margin_q)) <= {1'b0, full});
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// offset-binary coordinates
	assign u0x = p0_q[2*CB-1:CB] ^ SIGN_BIT;
	assign u1x = p1_q[2*CB-1:CB] ^ SIGN_BIT;
	assign u2x = p2_q[2*CB-1:CB] ^ SIGN_BIT;
	assign u0y = p0_q[CB-1:0] ^ SIGN_BIT;
	assign u1y = p1_q[CB-1:0] ^ SIGN_BIT;
	assign u2y = p2_q[CB-1:0] ^ SIGN_BIT;

	always_comb begin
		unique case (op_q)
			OP_AA: begin mul_a = MA_W'(a_q); mul_b = MB_W'(a_q); end
			OP_AB: begin mul_a = MA_W'(a_q); mul_b = MB_W'(i_q); end
			OP_BB: begin mul_a = MA_W'(i_q); mul_b = MB_W'(i_q); end
			OP_X0: begin mul_a = c0_q;       mul_b = MB_W'(u0x); end
			OP_X1: begin mul_a = c1_q;       mul_b = MB_W'(u1x); end
			OP_X2: begin mul_a = c2_q;       mul_b = MB_W'(u2x); end
			OP_Y0: begin mul_a = c0_q;       mul_b = MB_W'(u0y); end
			OP_Y1: begin mul_a = c1_q;       mul_b = MB_W'(u1y); end
			OP_Y2: begin mul_a = c2_q;       mul_b = MB_W'(u2y); end
			default: begin mul_a = '0;       mul_b = '0; end
		endcase
	end

	assign mul_en = (state_q == ST_MUL) && (op_q <= OP_Y2);

	qbpg_mul_unit #(
		.A_W (MA_W),
		.B_W (MB_W)
	) u_mul (
		.clk    (clk),
		.en     (mul_en),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod)
	);

	assign prod_n = prod[ACC_W-1:0];
	assign prod_2 = {prod_n[ACC_W-2:0], 1'b0};

	assign rx = acc_x_q >> {s_q, 1'b0};
	assign ry = acc_y_q >> {s_q, 1'b0};

	assign pix_x    = pixel_of(px_q);
	assign pix_y    = pixel_of(py_q);
	assign drop     = dedupe_q && middle_q && kept_valid_q &&
		(pix_x == kept_x_q) && (pix_y == kept_y_q);
	assign load_out = (state_q == ST_DECIDE) && !drop && (!out_valid_q || out_ready);

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_AA;
			kept_valid_q <= 1'b0;
			kept_x_q     <= '0;
			kept_y_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (step_index == '0) begin
							kept_valid_q <= 1'b0;
						end
						op_q <= OP_AA;
						if (in_range) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					op_q <= op_q + 4'd1;
					if (op_q == OP_DONE) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (drop) begin
						state_q <= ST_IDLE;
					end else if (load_out) begin
						state_q <= ST_IDLE;
						if (dedupe_q && middle_q) begin
							kept_valid_q <= 1'b1;
							kept_x_q     <= pix_x;
							kept_y_q     <= pix_y;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			i_q      <= step_index;
			a_q      <= full - step_index;
			s_q      <= s_eff;
			middle_q <= middle;
			acc_x_q  <= ACC_W'(1) << ({1'b0, s_eff, 1'b0} - (SHW+2)'(1));
			acc_y_q  <= ACC_W'(1) << ({1'b0, s_eff, 1'b0} - (SHW+2)'(1));
		end
		if (state_q == ST_MUL) begin
			// prod holds the result of the previous op
			unique case (op_q)
				OP_AB:   c0_q    <= prod[MA_W-1:0];
				OP_BB:   c1_q    <= prod[MA_W-1:0];
				OP_X0:   c2_q    <= prod[MA_W-1:0];
				OP_X1:   acc_x_q <= acc_x_q + prod_n;
				OP_X2:   acc_x_q <= acc_x_q + prod_2;
				OP_Y0:   acc_x_q <= acc_x_q + prod_n;
				OP_Y1:   acc_y_q <= acc_y_q + prod_n;
				OP_Y2:   acc_y_q <= acc_y_q + prod_2;
				OP_DONE: acc_y_q <= acc_y_q + prod_n;
				default: ;
			endcase
		end
		if (state_q == ST_SHIFT) begin
			px_q <= rx[CB-1:0] ^ SIGN_BIT;
			py_q <= ry[CB-1:0] ^ SIGN_BIT;
		end
		if (load_out) begin
			out_x_q    <= px_q;
			out_y_q    <= py_q;
			out_step_q <= i_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign point_x    = out_x_q;
	assign point_y    = out_y_q;
	assign point_step = out_step_q;

endmodule

### rtl/qbpg_mul_unit.sv
// Shared unsigned multiplier with registered product.
// No dependencies; used by the point generator top level.
module qbpg_mul_unit #(
	parameter int A_W = 29,
	parameter int B_W = 24
) (
	input  logic               clk,
	input  logic               en,
	input  logic [A_W-1:0]     op_a,
	input  logic [B_W-1:0]     op_b,
	output logic [A_W+B_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

endmodule

### rtl/qbpg_checker.sv
// Port-level checker for the quadratic Bezier point generator, with its bind.
// Depends on quadratic_bezier_point_generator_core_assert.svh.
`include "quadratic_bezier_point_generator_core_assert.svh"

module qbpg_checker #(
	parameter int COORD_BITS     = 24,
	parameter int MAX_STEP_SHIFT = 14
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [MAX_STEP_SHIFT:0]       step_index,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [COORD_BITS-1:0]  point_x,
	input logic signed [COORD_BITS-1:0]  point_y,
	input logic [MAX_STEP_SHIFT:0]       point_step
);

	localparam logic [MAX_STEP_SHIFT:0] STEP_FULL = {1'b1, {MAX_STEP_SHIFT{1'b0}}};

	`QBPG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(point_x) && $stable(point_y) && $stable(point_step),
		"result item changed while stalled")

	`QBPG_ASSERT_NEXT(a_busy_after_restart, clk, arst_n,
		in_valid && in_ready && (step_index == '0),
		!in_ready, "block ready again right after taking a restart item")

	`QBPG_ASSERT_NOW(a_result_from_work, clk, arst_n, $rose(out_valid),
		$past(!in_ready), "result item without an item in progress")

	`QBPG_ASSERT_NOW(a_step_range, clk, arst_n, out_valid,
		point_step <= STEP_FULL, "result step beyond the longest curve")

endmodule

bind quadratic_bezier_point_generator_core qbpg_checker #(
	.COORD_BITS     (COORD_BITS),
	.MAX_STEP_SHIFT (MAX_STEP_SHIFT)
) u_qbpg_checker (.*);

### test/quadratic_bezier_point_generator_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_bezier_point_generator_core: drives curve steps,
// predicts each emitted point (including dedupe) and checks every output item.
// Depends on qbpg_pkg and the core RTL.
module quadratic_bezier_point_generator_core_test;

	localparam int CW            = 24;
	localparam int SW            = 15;
	localparam int MAX_SHIFT     = 14;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 30;
	localparam int RANDOM_ITEMS  = 1750;
	localparam int MAX_PRINTS    = 40;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [SW-1:0]        step;
	} curve_point_t;

	typedef enum {RX_OPEN, RX_PATCHY, RX_STARVED} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	qbpg_pkg::cfg_idx_t   cfg_index;
	logic [2*CW-1:0]      cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [SW-1:0]        step_index;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [CW-1:0] point_x;
	logic signed [CW-1:0] point_y;
	logic [SW-1:0]        point_step;

	// shadow of the block's registers and dedupe state
	logic [2*CW-1:0] start_xy   = '0;
	logic [2*CW-1:0] control_xy = '0;
	logic [2*CW-1:0] end_xy     = '0;
	logic [3:0]      shift_reg  = qbpg_pkg::STEP_SHIFT_RST;
	logic [13:0]     margin_reg = 14'(qbpg_pkg::MARGIN_RST);
	logic            dedupe_reg = 1'b1;
	int              kept_px    = 0;
	int              kept_py    = 0;
	bit              kept_valid = 1'b0;

	curve_point_t expected_points[$];
	int           error_count = 0;
	int           cycle_count = 0;
	int           burst_left  = 0;
	int           hold_left   = 0;

	quadratic_bezier_point_generator_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.step_index (step_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_step (point_step)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("MISMATCH cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic logic [2*CW-1:0] xy(input int x, input int y);
		return {x[CW-1:0], y[CW-1:0]};
	endfunction

	function automatic int jitter(input int centre, input int spread);
		return centre + int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	function automatic logic [2*CW-1:0] random_xy();
		return (2*CW)'({$urandom(), $urandom()});
	endfunction

	// exact rational evaluation in offset binary, rounded to nearest, ties up
	function automatic logic [CW-1:0] curve_coord(input logic [CW-1:0] c0, input logic [CW-1:0] c1,
			input logic [CW-1:0] c2, input logic [63:0] a, input logic [63:0] b,
			input int unsigned s);
		logic [63:0] u0, u1, u2, sum, r;
		u0  = {40'd0, c0 ^ 24'h800000};
		u1  = {40'd0, c1 ^ 24'h800000};
		u2  = {40'd0, c2 ^ 24'h800000};
		sum = a * a * u0 + 2 * a * b * u1 + b * b * u2;
		r   = (sum + (64'd1 << (2 * s - 1))) >> (2 * s);
		return r[CW-1:0] ^ 24'h800000;
	endfunction

	// Q16.8 to whole pixel, half away from zero
	function automatic int round_pixel(input logic signed [CW-1:0] c);
		int v;
		v = c;
		if (v >= 0)
			return (v + 128) >>> 8;
		return -((-v + 128) >>> 8);
	endfunction

	task automatic predict_point(input logic [SW-1:0] idx);
		int unsigned  s;
		int           full, i_v, m_v, qx, qy;
		logic [CW-1:0] px, py;
		curve_point_t  pt;
		s = shift_reg;
		if (s < 1)
			s = 1;
		if (s > MAX_SHIFT)
			s = MAX_SHIFT;
		full = 1 << s;
		i_v  = idx;
		m_v  = margin_reg;
		if (i_v == 0)
			kept_valid = 1'b0;
		if (i_v > full)
			return;
		px = curve_coord(start_xy[47:24], control_xy[47:24], end_xy[47:24], full - i_v, i_v, s);
		py = curve_coord(start_xy[23:0], control_xy[23:0], end_xy[23:0], full - i_v, i_v, s);
		if (dedupe_reg && i_v >= m_v && i_v + m_v <= full) begin
			qx = round_pixel(px);
			qy = round_pixel(py);
			if (kept_valid && qx == kept_px && qy == kept_py)
				return;
			kept_px    = qx;
			kept_py    = qy;
			kept_valid = 1'b1;
		end
		pt.x    = px;
		pt.y    = py;
		pt.step = idx;
		expected_points.push_back(pt);
	endtask

	task automatic write_reg(input qbpg_pkg::cfg_idx_t idx, input logic [2*CW-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			qbpg_pkg::REG_START_POINT:   start_xy   = value;
			qbpg_pkg::REG_CONTROL_POINT: control_xy = value;
			qbpg_pkg::REG_END_POINT:     end_xy     = value;
			qbpg_pkg::REG_STEP_SHIFT:    shift_reg  = value[3:0];
			qbpg_pkg::REG_MARGIN_POINTS: margin_reg = value[13:0];
			qbpg_pkg::REG_DEDUPE_ENABLE: dedupe_reg = value[0];
			default: ;
		endcase
	endtask

	task automatic set_curve(input logic [2*CW-1:0] p0, input logic [2*CW-1:0] p1,
			input logic [2*CW-1:0] p2);
		write_reg(qbpg_pkg::REG_START_POINT, p0);
		write_reg(qbpg_pkg::REG_CONTROL_POINT, p1);
		write_reg(qbpg_pkg::REG_END_POINT, p2);
	endtask

	task automatic set_mode(input int shift, input int margin, input int dedupe);
		write_reg(qbpg_pkg::REG_STEP_SHIFT, (2*CW)'(shift));
		write_reg(qbpg_pkg::REG_MARGIN_POINTS, (2*CW)'(margin));
		write_reg(qbpg_pkg::REG_DEDUPE_ENABLE, (2*CW)'(dedupe));
	endtask

	task automatic send_step(input logic [SW-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		step_index <= idx;
		do @(posedge clk); while (!in_ready);
		predict_point(idx);
	endtask

	task automatic drain();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ascending walk over a curve with occasional stray and out-of-range steps
	task automatic run_sweep(input int full, input int stride_max, inout int placed);
		int idx, noise;
		idx = ($urandom_range(0, 7) == 0) ? $urandom_range(1, full) : 0;
		while (idx <= full) begin
			if ($urandom_range(0, 19) == 0) begin
				noise = $urandom_range(0, 32767);
				send_step(SW'(noise));
				if (noise <= full)
					placed++;
			end
			send_step(SW'(idx));
			placed++;
			idx += $urandom_range(1, stride_max);
		end
		if ($urandom_range(0, 2) == 0)
			send_step(SW'($urandom_range(full + 1, 32767)));
	endtask

	always @(posedge clk) begin
		curve_point_t pt;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				report_mismatch($sformatf("unexpected point step %0d x %0d y %0d",
					point_step, point_x, point_y));
			end else begin
				pt = expected_points.pop_front();
				if (point_x !== pt.x || point_y !== pt.y || point_step !== pt.step)
					report_mismatch($sformatf("step %0d x %0d y %0d, expected step %0d x %0d y %0d",
						point_step, point_x, point_y, pt.step, pt.x, pt.y));
			end
		end
	end

	// receiver: open, patchy and starved stretches, plus long hold-offs on request
	initial begin
		rx_mode_t mode;
		int       mode_left;
		out_ready = 1'b0;
		mode      = RX_OPEN;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_PATCHY: out_ready <= $urandom_range(0, 1);
					default:   out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// reset values: flat curve at the origin, 8192 steps, margin 81, dedupe on
	task automatic test_reset_defaults();
		send_step(0);
		send_step(1);
		send_step(81);
		send_step(82);
		send_step(8111);
		send_step(8112);
		send_step(8192);
		send_step(8193);
		send_step(32767);
		drain();
	endtask

	task automatic test_extremes();
		set_curve(xy(-8388608, 8388607), xy(8388607, -8388608), xy(-8388608, -8388608));
		set_mode(1, 0, 0);
		send_step(0);
		send_step(1);
		send_step(2);
		send_step(3);
		drain();
		// zero shift acts as one
		write_reg(qbpg_pkg::REG_STEP_SHIFT, '0);
		send_step(1);
		send_step(2);
		drain();
		// shift above the maximum, margins covering the whole curve
		set_curve(xy(8388607, 8388607), xy(0, 0), xy(-1, 1));
		set_mode(15, 16383, 1);
		send_step(0);
		send_step(8192);
		send_step(16384);
		send_step(16385);
		drain();
		// half-pixel ties and restart at step zero
		set_curve(xy(127, -127), xy(127, -127), xy(128, -128));
		set_mode(1, 0, 1);
		send_step(0);
		send_step(1);
		send_step(2);
		send_step(0);
		send_step(1);
		drain();
	endtask

	task automatic test_backpressure();
		set_curve(random_xy(), random_xy(), random_xy());
		set_mode(5, 2, 0);
		hold_left = 800;
		for (int i = 0; i <= 32; i++)
			send_step(SW'(i));
		drain();
	endtask

	task automatic test_random_curves();
		int placed, sel, shift, s, full, margin, stride_max, cx, cy, spread;
		placed = 0;
		while (placed < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 19);
			if (sel == 0)
				shift = 0;
			else if (sel == 1)
				shift = 15;
			else if (sel < 4)
				shift = $urandom_range(8, MAX_SHIFT);
			else
				shift = $urandom_range(1, 7);
			s    = (shift < 1) ? 1 : (shift > MAX_SHIFT) ? MAX_SHIFT : shift;
			full = 1 << s;
			sel  = $urandom_range(0, 9);
			if (sel == 0)
				margin = $urandom_range(full / 2, 16383);
			else if (sel == 1)
				margin = 0;
			else
				margin = $urandom_range(0, full / 4 + 1);
			if ($urandom_range(0, 2) == 0) begin
				set_curve(random_xy(), random_xy(), random_xy());
			end else begin
				cx     = $urandom_range(0, 24'hFFFFFF);
				cy     = $urandom_range(0, 24'hFFFFFF);
				spread = $urandom_range(16, 2048);
				set_curve(xy(jitter(cx, spread), jitter(cy, spread)),
					xy(jitter(cx, spread), jitter(cy, spread)),
					xy(jitter(cx, spread), jitter(cy, spread)));
			end
			set_mode(shift, margin, $urandom_range(0, 3) != 0);
			if (s > 7)
				stride_max = full >> 6;
			else
				stride_max = ($urandom_range(0, 4) == 0) ? 3 : 1;
			run_sweep(full, stride_max, placed);
			drain();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = qbpg_pkg::REG_START_POINT;
		cfg_data   = '0;
		in_valid   = 1'b0;
		step_index = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_extremes();
		test_backpressure();
		test_random_curves();
		if (expected_points.size() != 0)
			report_mismatch($sformatf("%0d expected points never arrived",
				expected_points.size()));
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
